// File: design/dda_pkg.sv
package dda_pkg;

  localparam int unsigned COORD_BITS = 10;
  localparam int unsigned FRAC_BITS  = 16;

  // accumulator: integer part with one guard bit above, then the fraction
  localparam int unsigned ACC_BITS = COORD_BITS + 1 + FRAC_BITS;
  // step counter holds the pixel count of the longest line
  localparam int unsigned CNT_BITS = COORD_BITS + 1;
  // dividend is |d| shifted up by the fraction plus half the divisor
  localparam int unsigned DVD_BITS = COORD_BITS + FRAC_BITS;
  localparam int unsigned DIV_CNT_BITS = $clog2(DVD_BITS);

  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  typedef struct packed {
    logic                  action;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;
  } out_item_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

endpackage

// File: design/dda_div.sv
module dda_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [dda_pkg::DVD_BITS-1:0]  dividend_i,
  input  logic [dda_pkg::CNT_BITS-1:0]  divisor_i,
  output logic                          done_o,
  output logic [dda_pkg::DVD_BITS-1:0]  quotient_o
);
  import dda_pkg::*;

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [CNT_BITS-1:0]     rem_q, rem_d;
  logic [CNT_BITS-1:0]     dsr_q, dsr_d;
  logic [DVD_BITS-1:0]     dvd_q, dvd_d;
  logic [CNT_BITS:0]       rem_sh;
  logic [CNT_BITS:0]       rem_sub;
  logic                    q_bit;

  // one restoring step: bring down the next dividend bit, trial subtract
  assign rem_sh  = {rem_q, dvd_q[DVD_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign q_bit   = (rem_sh >= {1'b0, dsr_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    dvd_d  = dvd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dsr_d  = divisor_i;
      dvd_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = q_bit ? rem_sub[CNT_BITS-1:0] : rem_sh[CNT_BITS-1:0];
      // quotient bits fill in from the bottom as the dividend leaves the top
      dvd_d = {dvd_q[DVD_BITS-2:0], q_bit};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_BITS'(DVD_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
      dvd_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      dsr_q  <= dsr_d;
      dvd_q  <= dvd_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

  // the remainder must stay below the divisor between steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < dsr_q))
    else $error("divider remainder not below divisor");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

endmodule

// File: design/dda_line_rasterizer.sv
// DDA line generator.
// Input channel (in_valid_i / in_ready_o / in_item_i): an item with action
// start loads two endpoints; an item with action advance moves one pixel
// along the current line. Output channel (out_valid_o / out_ready_i /
// out_item_o): one pixel per start item and per advance item of an active
// line, last_pixel set on the end point. Advance items while no line is
// active are taken and give nothing.
// A pixel is registered into the output register in the cycle after its item
// is taken. Advance items are taken back to back, so pixels stream at one per
// cycle while the receiver keeps reading. A start item with distinct
// endpoints then holds in_ready_o low while one shared restoring divider
// produces the x and then the y increment, one quotient bit a cycle. A
// zero-length line gives its single pixel and needs no division.
// The output register is free to take a new pixel when it is empty or
// being read in the same cycle; while the receiver stalls, input is held
// off. Reset empties the output register and leaves no line active.
module dda_line_rasterizer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dda_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dda_pkg::out_item_t  out_item_o
);
  import dda_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV_X,
    S_DIV_Y
  } state_e;

  state_e                state_q, state_d;
  logic [ACC_BITS-1:0]   x_acc_q, x_acc_d, y_acc_q, y_acc_d;
  logic [ACC_BITS-1:0]   x_step_q, x_step_d, y_step_q, y_step_d;
  logic [CNT_BITS-1:0]   left_q, left_d;
  logic                  active_q, active_d;
  logic [COORD_BITS-1:0] x_mag_q, x_mag_d, y_mag_q, y_mag_d;
  logic                  x_neg_q, x_neg_d, y_neg_q, y_neg_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;
  div_ctrl_t             div_q, div_d;

  logic                  take;
  logic [COORD_BITS-1:0] adx, ady, steps;
  logic [CNT_BITS-1:0]   left_dec;
  logic [ACC_BITS-1:0]   x_acc_nx, y_acc_nx, x_acc_init, y_acc_init;
  logic [COORD_BITS-1:0] div_mag;
  logic [DVD_BITS-1:0]   dividend;
  logic [DVD_BITS-1:0]   quotient;
  logic [ACC_BITS-1:0]   q_ext;
  logic                  div_done;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign take       = in_valid_i && in_ready_o;

  assign adx   = (in_item_i.x_end >= in_item_i.x_start) ?
                 (in_item_i.x_end - in_item_i.x_start) : (in_item_i.x_start - in_item_i.x_end);
  assign ady   = (in_item_i.y_end >= in_item_i.y_start) ?
                 (in_item_i.y_end - in_item_i.y_start) : (in_item_i.y_start - in_item_i.y_end);
  assign steps = (adx > ady) ? adx : ady;

  // start a half unit in so the integer part rounds to the nearest pixel
  assign x_acc_init = {1'b0, in_item_i.x_start, 1'b1, {(FRAC_BITS-1){1'b0}}};
  assign y_acc_init = {1'b0, in_item_i.y_start, 1'b1, {(FRAC_BITS-1){1'b0}}};
  assign x_acc_nx   = x_acc_q + x_step_q;
  assign y_acc_nx   = y_acc_q + y_step_q;
  assign left_dec   = left_q - 1'b1;

  // rounded division: add half the divisor to the scaled magnitude
  assign div_mag  = (state_q == S_DIV_Y) ? y_mag_q : x_mag_q;
  assign dividend = {div_mag, {FRAC_BITS{1'b0}}} + DVD_BITS'(left_q >> 1);
  assign q_ext    = ACC_BITS'(quotient);

  dda_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_q.start),
    .dividend_i (dividend),
    .divisor_i  (left_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    state_d     = state_q;
    x_acc_d     = x_acc_q;
    y_acc_d     = y_acc_q;
    x_step_d    = x_step_q;
    y_step_d    = y_step_q;
    left_d      = left_q;
    active_d    = active_q;
    x_mag_d     = x_mag_q;
    y_mag_d     = y_mag_q;
    x_neg_d     = x_neg_q;
    y_neg_d     = y_neg_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    div_d.start = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (take && in_item_i.action == ACT_START) begin
          x_acc_d            = x_acc_init;
          y_acc_d            = y_acc_init;
          x_step_d           = '0;
          y_step_d           = '0;
          left_d             = CNT_BITS'(steps);
          active_d           = 1'b0;
          x_mag_d            = adx;
          y_mag_d            = ady;
          x_neg_d            = in_item_i.x_end < in_item_i.x_start;
          y_neg_d            = in_item_i.y_end < in_item_i.y_start;
          out_valid_d        = 1'b1;
          out_d.pixel_x      = in_item_i.x_start;
          out_d.pixel_y      = in_item_i.y_start;
          out_d.last_pixel   = (steps == '0);
          if (steps != '0) begin
            div_d.start = 1'b1;
            state_d     = S_DIV_X;
          end
        end else if (take && active_q) begin
          x_acc_d          = x_acc_nx;
          y_acc_d          = y_acc_nx;
          left_d           = left_dec;
          active_d         = (left_dec != '0);
          out_valid_d      = 1'b1;
          out_d.pixel_x    = x_acc_nx[FRAC_BITS +: COORD_BITS];
          out_d.pixel_y    = y_acc_nx[FRAC_BITS +: COORD_BITS];
          out_d.last_pixel = (left_dec == '0);
        end
      end
      S_DIV_X: begin
        if (div_done) begin
          x_step_d    = x_neg_q ? (ACC_BITS'(0) - q_ext) : q_ext;
          div_d.start = 1'b1;
          state_d     = S_DIV_Y;
        end
      end
      S_DIV_Y: begin
        if (div_done) begin
          y_step_d = y_neg_q ? (ACC_BITS'(0) - q_ext) : q_ext;
          active_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      x_acc_q     <= '0;
      y_acc_q     <= '0;
      x_step_q    <= '0;
      y_step_q    <= '0;
      left_q      <= '0;
      active_q    <= 1'b0;
      x_mag_q     <= '0;
      y_mag_q     <= '0;
      x_neg_q     <= 1'b0;
      y_neg_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      div_q       <= '0;
    end else begin
      state_q     <= state_d;
      x_acc_q     <= x_acc_d;
      y_acc_q     <= y_acc_d;
      x_step_q    <= x_step_d;
      y_step_q    <= y_step_d;
      left_q      <= left_d;
      active_q    <= active_d;
      x_mag_q     <= x_mag_d;
      y_mag_q     <= y_mag_d;
      x_neg_q     <= x_neg_d;
      y_neg_q     <= y_neg_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      div_q       <= div_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // an active line always has pixels left to give
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (left_q != '0))
    else $error("active line with no steps left");

  // a waiting end-of-line pixel means the line is finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.last_pixel) |-> !active_q)
    else $error("last pixel shown while line still active");

  // the divider only finishes while the sequencer waits on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV_X || state_q == S_DIV_Y))
    else $error("divider result outside a division state");

  // the x division leaves the step count untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV_X && !div_done) |=> $stable(left_q))
    else $error("step count changed during division");

endmodule
